// ===== sv/mep_pkg.sv =====
// Shared types and constants of the escape-time pixel engine.
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

    // Q4.28 fixed point for the origins; 28 fraction bits throughout
    localparam int FRAC_BITS = 28;

    localparam int PIX_W     = 12;
    localparam int ORG_W     = 32;
    localparam int STEP_W    = 31;
    localparam int CNT_W     = 16;
    localparam int GRAY_W    = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // c = origin + index * step
    localparam int PROD_W = PIX_W + STEP_W;
    localparam int C_W    = PROD_W + 2;
    // z = sr - si + c, where |sr - si| stays within 4.0
    localparam int Z_W    = ((C_W > FRAC_BITS + 4) ? C_W : FRAC_BITS + 4) + 1;
    // multiplier operand once |z| <= 2.0 is known
    localparam int M_W    = FRAC_BITS + 3;
    // floored product, magnitude within 8.0
    localparam int P_W    = FRAC_BITS + 5;

    localparam logic signed [Z_W-1:0] Z_TWO  = Z_W'(64'd1 << (FRAC_BITS + 1));
    localparam logic signed [P_W:0]   S_FOUR = (P_W + 1)'(64'd1 << (FRAC_BITS + 2));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_REAL = 3'd0,
        CFG_ORIGIN_IMAG = 3'd1,
        CFG_STEP_REAL   = 3'd2,
        CFG_STEP_IMAG   = 3'd3,
        CFG_MAX_ITER    = 3'd4
    } t_cfg_idx;

    localparam logic [ORG_W-1:0]  RST_ORIGIN_REAL = 32'hD000_0000;
    localparam logic [ORG_W-1:0]  RST_ORIGIN_IMAG = 32'hF000_0000;
    localparam logic [STEP_W-1:0] RST_STEP_REAL   = 31'd1468006;
    localparam logic [STEP_W-1:0] RST_STEP_IMAG   = 31'd1118481;
    localparam logic [CNT_W-1:0]  RST_MAX_ITER    = 16'd1000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [CNT_W-1:0]  iteration_count;
        logic [GRAY_W-1:0] gray_level;
        logic              hit_limit;
    } t_result;

    typedef struct packed {
        logic signed [C_W-1:0] c_real;
        logic signed [C_W-1:0] c_imag;
    } t_point;

    typedef struct packed {
        logic   push;
        t_point point;
    } t_push;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } t_state;

endpackage

`default_nettype wire

// ===== sv/mep_front.sv =====
// Front end: configuration registers, request intake and mapping to the point c.
`timescale 1ns / 1ps
`default_nettype none

module mep_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire mep_pkg::t_pixel              i_pixel,
    input  wire logic                         i_cfg_we,
    input  wire logic [mep_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [mep_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                         i_full,
    output mep_pkg::t_push                    o_push,
    output logic [mep_pkg::CNT_W-1:0]         o_max_iter
);
    import mep_pkg::*;

    logic [ORG_W-1:0]  r_origin_re;
    logic [ORG_W-1:0]  r_origin_im;
    logic [STEP_W-1:0] r_step_re;
    logic [STEP_W-1:0] r_step_im;
    logic [CNT_W-1:0]  r_max_iter;

    logic              r_valid;
    logic              n_valid;
    t_pixel            r_pixel;

    logic              accept;
    logic              push;
    logic [PROD_W-1:0] prod_re;
    logic [PROD_W-1:0] prod_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= RST_ORIGIN_REAL;
            r_origin_im <= RST_ORIGIN_IMAG;
            r_step_re   <= RST_STEP_REAL;
            r_step_im   <= RST_STEP_IMAG;
            r_max_iter  <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ORIGIN_REAL: r_origin_re <= i_cfg_wdata[ORG_W-1:0];
                CFG_ORIGIN_IMAG: r_origin_im <= i_cfg_wdata[ORG_W-1:0];
                CFG_STEP_REAL:   r_step_re   <= i_cfg_wdata[STEP_W-1:0];
                CFG_STEP_IMAG:   r_step_im   <= i_cfg_wdata[STEP_W-1:0];
                CFG_MAX_ITER:    r_max_iter  <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // hold a request only while the queue is full
    assign o_busy = r_valid && i_full;
    assign accept = i_start && !o_busy;
    assign push   = r_valid && !i_full;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= i_pixel;
        end
    end

    assign prod_re = PROD_W'(r_pixel.pixel_x) * PROD_W'(r_step_re);
    assign prod_im = PROD_W'(r_pixel.pixel_y) * PROD_W'(r_step_im);

    assign o_push.push         = push;
    assign o_push.point.c_real = $signed({{(C_W-ORG_W){r_origin_re[ORG_W-1]}}, r_origin_re})
                               + $signed({{(C_W-PROD_W){1'b0}}, prod_re});
    assign o_push.point.c_imag = $signed({{(C_W-ORG_W){r_origin_im[ORG_W-1]}}, r_origin_im})
                               + $signed({{(C_W-PROD_W){1'b0}}, prod_im});
    assign o_max_iter          = r_max_iter;

endmodule

`default_nettype wire

// ===== sv/mep_queue.sv =====
// Small FIFO of mapped points between the front end and the iteration core.
`timescale 1ns / 1ps
`default_nettype none

module mep_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mep_pkg::t_push  i_push,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output mep_pkg::t_point      o_point
);
    import mep_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_point             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_point = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.point;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mep_core.sv =====
// Iteration core: z = z*z + c on one shared multiplier set, a multiply state then an add state per step.
`timescale 1ns / 1ps
`default_nettype none

module mep_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  wire mep_pkg::t_point        i_point,
    output logic                        o_pop,
    input  wire logic [mep_pkg::CNT_W-1:0] i_max_iter,
    output logic                        o_done,
    output mep_pkg::t_result            o_result
);
    import mep_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic signed [C_W-1:0] r_cr;
    logic signed [C_W-1:0] r_ci;
    logic signed [C_W-1:0] n_cr;
    logic signed [C_W-1:0] n_ci;
    logic signed [Z_W-1:0] r_zr;
    logic signed [Z_W-1:0] r_zi;
    logic signed [Z_W-1:0] n_zr;
    logic signed [Z_W-1:0] n_zi;
    logic signed [P_W-1:0] r_sr;
    logic signed [P_W-1:0] r_si;
    logic signed [P_W-1:0] r_sx;
    logic signed [P_W-1:0] n_sr;
    logic signed [P_W-1:0] n_si;
    logic signed [P_W-1:0] n_sx;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_done;
    logic                  n_done;
    t_result               r_result;
    t_result               n_result;

    logic                  in_range;
    logic                  at_limit;
    logic                  mag_escape;
    logic signed [M_W-1:0]   zr_m;
    logic signed [M_W-1:0]   zi_m;
    logic signed [M_W:0]     zr2_m;
    logic signed [2*M_W-1:0] p_rr;
    logic signed [2*M_W-1:0] p_ii;
    logic signed [2*M_W:0]   p_ri;
    logic signed [2*M_W-1:0] f_rr;
    logic signed [2*M_W-1:0] f_ii;
    logic signed [2*M_W:0]   f_ri;
    logic signed [P_W:0]     mag_sum;
    logic signed [Z_W-1:0]   sr_x;
    logic signed [Z_W-1:0]   si_x;
    logic signed [Z_W-1:0]   sx_x;

    // escape test on |zr|, |zi| before the operands are narrowed
    assign in_range = (r_zr <= Z_TWO) && (r_zr >= -Z_TWO)
                   && (r_zi <= Z_TWO) && (r_zi >= -Z_TWO);
    assign at_limit = (r_count >= i_max_iter);

    assign zr_m  = r_zr[M_W-1:0];
    assign zi_m  = r_zi[M_W-1:0];
    assign zr2_m = {zr_m, 1'b0};
    assign p_rr  = zr_m * zr_m;
    assign p_ii  = zi_m * zi_m;
    assign p_ri  = zr2_m * zi_m;
    // arithmetic shift floors toward minus infinity
    assign f_rr  = p_rr >>> FRAC_BITS;
    assign f_ii  = p_ii >>> FRAC_BITS;
    assign f_ri  = p_ri >>> FRAC_BITS;

    assign mag_sum    = {r_sr[P_W-1], r_sr} + {r_si[P_W-1], r_si};
    assign mag_escape = (mag_sum > S_FOUR);

    assign sr_x = {{(Z_W-P_W){r_sr[P_W-1]}}, r_sr};
    assign si_x = {{(Z_W-P_W){r_si[P_W-1]}}, r_si};
    assign sx_x = {{(Z_W-P_W){r_sx[P_W-1]}}, r_sx};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (at_limit || !in_range) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (mag_escape) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_zr     = r_zr;
        n_zi     = r_zi;
        n_sr     = r_sr;
        n_si     = r_si;
        n_sx     = r_sx;
        n_count  = r_count;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cr    = i_point.c_real;
                    n_ci    = i_point.c_imag;
                    n_zr    = '0;
                    n_zi    = '0;
                    n_count = '0;
                end
            end
            ST_MUL: begin
                n_sr = f_rr[P_W-1:0];
                n_si = f_ii[P_W-1:0];
                n_sx = f_ri[P_W-1:0];
                if (at_limit || !in_range) begin
                    n_done                   = 1'b1;
                    n_result.iteration_count = r_count;
                    n_result.gray_level      = r_count[GRAY_W-1:0];
                    n_result.hit_limit       = (r_count == i_max_iter);
                end
            end
            ST_ADD: begin
                if (mag_escape) begin
                    n_done                   = 1'b1;
                    n_result.iteration_count = r_count;
                    n_result.gray_level      = r_count[GRAY_W-1:0];
                    n_result.hit_limit       = (r_count == i_max_iter);
                end else begin
                    n_zr    = sr_x - si_x + {{(Z_W-C_W){r_cr[C_W-1]}}, r_cr};
                    n_zi    = sx_x + {{(Z_W-C_W){r_ci[C_W-1]}}, r_ci};
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr     <= n_cr;
        r_ci     <= n_ci;
        r_zr     <= n_zr;
        r_zi     <= n_zi;
        r_sr     <= n_sr;
        r_si     <= n_si;
        r_sx     <= n_sx;
        r_count  <= n_count;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== sv/mandelbrot_escape_time_pixel.sv =====
// Escape-time pixel engine: front end, point queue and iteration core.
// A request is registered in the front end, queued, popped by the idle core and iterated; o_done is registered.
// The single iteration core takes a new pixel only once the last one is done, stepping through
//   its multiply/accumulate loop of alternating multiply and add states.
// Up to QUEUE_DEPTH + 1 requests wait ahead of the core; o_busy rises when all are taken.
// Synchronous active-low reset restores the default registers and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_pixel #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire mep_pkg::t_pixel               i_pixel,
    input  wire logic                          i_cfg_we,
    input  wire logic [mep_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [mep_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                               o_done,
    output mep_pkg::t_result                   o_result
);
    import mep_pkg::*;

    t_push            push;
    t_point           point;
    logic             full;
    logic             empty;
    logic             pop;
    logic [CNT_W-1:0] max_iter;

    mep_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_max_iter  (max_iter)
    );

    mep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_point (point)
    );

    mep_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_point    (point),
        .o_pop      (pop),
        .i_max_iter (max_iter),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

// ===== sv/mep_checker.sv =====
// Port-level checks of the pixel engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mep_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_busy,
    input wire logic             o_done,
    input wire mep_pkg::t_result o_result
);
    import mep_pkg::*;

    // the core returns to idle and fetches before it can finish again
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.gray_level == o_result.iteration_count[GRAY_W-1:0]))
        else $error("gray level differs from count low byte");

    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (!o_done && !o_busy))
        else $error("result or busy right after reset");

endmodule

bind mandelbrot_escape_time_pixel mep_checker u_mep_checker (.*);

`default_nettype wire

// ===== bench/mep_escape_checker.sv =====
// Escape-time checker: mirrors the registers, predicts each pixel and compares results.
`timescale 1ns / 1ps

module mep_escape_checker
    import mep_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire t_pixel               i_pixel,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_done,
    input  wire t_result              i_result,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_limit_hits
);

    localparam longint TWO_Q  = longint'(1) << (FRAC_BITS + 1);
    localparam longint FOUR_Q = longint'(1) << (FRAC_BITS + 2);

    // register mirror, widened so that c and z never wrap
    longint           org_re;
    longint           org_im;
    longint           step_re;
    longint           step_im;
    logic [CNT_W-1:0] iter_limit;

    t_result pending_results[$];
    int      mismatches = 0;
    int      compared   = 0;
    int      limit_hits = 0;

    // Iterate z = z*z + c from zero; products are floored fixed point.
    function automatic t_result escape_time_of(input t_pixel p);
        longint      c_re;
        longint      c_im;
        longint      z_re;
        longint      z_im;
        longint      sq_re;
        longint      sq_im;
        longint      nxt_re;
        int unsigned n;
        bit          escaped;
        t_result     r;
        c_re    = org_re + longint'(p.pixel_x) * step_re;
        c_im    = org_im + longint'(p.pixel_y) * step_im;
        z_re    = 0;
        z_im    = 0;
        n       = 0;
        escaped = 1'b0;
        while (!escaped && n < iter_limit) begin
            if (z_re > TWO_Q || z_re < -TWO_Q || z_im > TWO_Q || z_im < -TWO_Q) begin
                escaped = 1'b1;
            end else begin
                sq_re = (z_re * z_re) >>> FRAC_BITS;
                sq_im = (z_im * z_im) >>> FRAC_BITS;
                if (sq_re + sq_im > FOUR_Q) begin
                    escaped = 1'b1;
                end else begin
                    nxt_re = sq_re - sq_im + c_re;
                    z_im   = ((2 * z_re * z_im) >>> FRAC_BITS) + c_im;
                    z_re   = nxt_re;
                    n++;
                end
            end
        end
        r.iteration_count = n[CNT_W-1:0];
        r.gray_level      = n[GRAY_W-1:0];
        r.hit_limit       = (n == iter_limit);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            org_re     = longint'($signed(RST_ORIGIN_REAL));
            org_im     = longint'($signed(RST_ORIGIN_IMAG));
            step_re    = longint'(RST_STEP_REAL);
            step_im    = longint'(RST_STEP_IMAG);
            iter_limit = RST_MAX_ITER;
            pending_results.delete();
        end else begin
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request waiting, expected none, actual %0d/%0d/%0b",
                             $time, i_result.iteration_count, i_result.gray_level,
                             i_result.hit_limit);
                end else begin
                    want = pending_results.pop_front();
                    compared++;
                    if (want.hit_limit) limit_hits++;
                    if (i_result.iteration_count !== want.iteration_count) begin
                        mismatches++;
                        $display("%0t: iteration_count expected %0d actual %0d",
                                 $time, want.iteration_count, i_result.iteration_count);
                    end
                    if (i_result.gray_level !== want.gray_level) begin
                        mismatches++;
                        $display("%0t: gray_level expected %0d actual %0d",
                                 $time, want.gray_level, i_result.gray_level);
                    end
                    if (i_result.hit_limit !== want.hit_limit) begin
                        mismatches++;
                        $display("%0t: hit_limit expected %0b actual %0b",
                                 $time, want.hit_limit, i_result.hit_limit);
                    end
                end
            end
            // predict with the registers as they stand before this edge's write
            if (i_start && !i_busy) pending_results.push_back(escape_time_of(i_pixel));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ORIGIN_REAL: org_re     = longint'($signed(i_cfg_wdata));
                    CFG_ORIGIN_IMAG: org_im     = longint'($signed(i_cfg_wdata));
                    CFG_STEP_REAL:   step_re    = longint'(i_cfg_wdata[STEP_W-1:0]);
                    CFG_STEP_IMAG:   step_im    = longint'(i_cfg_wdata[STEP_W-1:0]);
                    CFG_MAX_ITER:    iter_limit = i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= pending_results.size();
        o_errors     <= mismatches;
        o_checked    <= compared;
        o_limit_hits <= limit_hits;
    end

endmodule

// ===== bench/mandelbrot_escape_time_pixel_tb.sv =====
// Testbench top: pixel and register stimulus for the escape-time engine, and the verdict.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_tb;

    import mep_pkg::*;

    localparam int PIXEL_TARGET  = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_NS      = 100_000_000;
    localparam int Q_ONE         = 1 << FRAC_BITS;
    localparam int PIX_MAX       = (1 << PIX_W) - 1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    t_pixel               i_pixel     = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_busy;
    logic                 o_done;
    t_result              o_result;

    int errors;
    int pending;
    int checked;
    int limit_hits;

    int requests   = 0;
    int settings   = 0;
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    always #5 i_clk = ~i_clk;

    mandelbrot_escape_time_pixel dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_pixel    (i_pixel),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    mep_escape_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_done      (o_done),
        .i_result    (o_result),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_limit_hits(limit_hits)
    );

    function automatic t_pixel pix(input int x, input int y);
        t_pixel p;
        p.pixel_x = x[PIX_W-1:0];
        p.pixel_y = y[PIX_W-1:0];
        return p;
    endfunction

    // Mostly inside the visible window, sometimes anywhere in the field range.
    function automatic t_pixel rand_pixel(input int x_hi, input int y_hi);
        if ($urandom_range(0, 4) == 0) return pix($urandom_range(0, PIX_MAX),
                                                  $urandom_range(0, PIX_MAX));
        return pix($urandom_range(0, x_hi), $urandom_range(0, y_hi));
    endfunction

    // Hold the request until taken, then maybe drop start for a random gap.
    task automatic send_pixel(input t_pixel p);
        int gap;
        i_start <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (o_busy);
        requests++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gaps_on) begin
                gap = $urandom_range(1, 60);
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] org_re, input logic [CFG_W-1:0] org_im,
                                 input logic [CFG_W-1:0] step_re, input logic [CFG_W-1:0] step_im,
                                 input logic [CFG_W-1:0] iter_max);
        write_reg(CFG_ORIGIN_REAL, org_re);
        write_reg(CFG_ORIGIN_IMAG, org_im);
        write_reg(CFG_STEP_REAL, step_re);
        write_reg(CFG_STEP_IMAG, step_im);
        write_reg(CFG_MAX_ITER, iter_max);
        settings++;
    endtask

    initial begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        int          n_items;
        int          kind;
        logic [31:0] iter_max;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset view: corners, alternating bits, and a point near zero that never escapes
        settings++;
        send_pixel(pix(0, 0));
        send_pixel(pix(PIX_MAX, PIX_MAX));
        send_pixel(pix(PIX_MAX, 0));
        send_pixel(pix(0, PIX_MAX));
        send_pixel(pix(548, 240));
        send_pixel(pix('hAAA, 'h555));
        send_pixel(pix('h555, 'hAAA));
        for (int k = 0; k < 40; k++) send_pixel(rand_pixel(800, 480));
        wait_idle();

        // writes to unused indexes must leave the registers alone
        for (int a = int'(CFG_MAX_ITER) + 1; a < (1 << CFG_IDX_W); a++)
            write_reg(a[CFG_IDX_W-1:0], $urandom);
        send_pixel(pix(548, 240));
        send_pixel(rand_pixel(800, 480));
        wait_idle();

        // zero limit: no iterations, limit flag set
        apply_setting(-2 * Q_ONE, -Q_ONE, Q_ONE >> 8, Q_ONE >> 8, 0);
        send_pixel(pix(0, 0));
        send_pixel(pix(PIX_MAX, PIX_MAX));
        send_pixel(pix(256, 256));
        wait_idle();

        // most negative and positive origins, widest steps; upper bits of wide writes dropped
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(pix(0, 0));
        send_pixel(pix(PIX_MAX, PIX_MAX));
        send_pixel(pix(1, 1));
        wait_idle();

        // largest limit on c = 0, which never escapes, and on the far corner
        apply_setting(0, 0, 1 << 20, 1 << 20, (1 << CNT_W) - 1);
        send_pixel(pix(0, 0));
        send_pixel(pix(PIX_MAX, PIX_MAX));
        wait_idle();

        // c = -2 exactly sits on the escape boundary and stays there; zero steps
        apply_setting(-2 * Q_ONE, 0, 0, 0, 300);
        send_pixel(pix(0, 0));
        send_pixel(pix(PIX_MAX, PIX_MAX));
        send_pixel(pix(1234, 777));
        wait_idle();

        while (requests < PIXEL_TARGET) begin
            kind    = $urandom_range(0, 3);
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0: iter_max = 1;
                1: iter_max = 2;
                2: iter_max = 16;
                3: iter_max = 255;
                4: iter_max = 256;
                5: iter_max = 257;
                default: iter_max = $urandom_range(1, 300);
            endcase
            if (kind == 3) begin
                // anything goes; junk above the limit field must be ignored
                apply_setting($urandom, $urandom, $urandom, $urandom,
                              ($urandom & 32'hFFFF_0000) | $urandom_range(1, 512));
            end else begin
                apply_setting(-(5 * Q_ONE / 2) + int'($urandom_range(0, 3 * Q_ONE)),
                              -(6 * Q_ONE / 5) + int'($urandom_range(0, (Q_ONE / 5) * 12)),
                              $urandom_range(1 << 12, 1 << 22),
                              $urandom_range(1 << 12, 1 << 22), iter_max);
            end
            n_items = $urandom_range(30, 70);
            for (int k = 0; k < n_items; k++) send_pixel(rand_pixel(511, 511));
            wait_idle();
        end

        $display("covered %0d pixel requests under %0d register settings", requests, settings);
        $display("%0d results compared, %0d of them at the iteration limit", checked, limit_hits);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
